// ===== src/ars_pkg.sv =====
package ars_pkg;

   // Input item carried on the req_ channel
   typedef struct packed {
      logic       sense_active;
      logic [9:0] battery_sample;
   } req_type;

   // Result item carried on the rsp_ channel
   typedef struct packed {
      logic        send_now;
      logic [11:0] alert_message;
      logic        battery_used;
      logic        mail_flag_out;
      logic        low_battery_out;
   } rsp_type;

   // Register indexes on the csr_ channel
   localparam logic [2:0] REG_LOW_BATTERY_THRESHOLD  = 3'd0;
   localparam logic [2:0] REG_BATTERY_CHECK_INTERVAL = 3'd1;
   localparam logic [2:0] REG_REPEAT_PERIOD_FIRST    = 3'd2;
   localparam logic [2:0] REG_REPEAT_PERIOD_SECOND   = 3'd3;
   localparam logic [2:0] REG_REPEAT_PERIOD_THIRD    = 3'd4;
   localparam logic [2:0] REG_REPEAT_PERIOD_FOURTH   = 3'd5;

   localparam logic [11:0] MSG_BASE     = 12'hF20;
   localparam logic [2:0]  REPEAT_COUNT = 3'd4;

   localparam logic [9:0]  THRESHOLD_RESET = 10'd635;
   localparam logic [15:0] INTERVAL_RESET  = 16'd14400;
   localparam logic [13:0] PERIOD_FIRST_RESET  = 14'd8;
   localparam logic [13:0] PERIOD_SECOND_RESET = 14'd22;
   localparam logic [13:0] PERIOD_THIRD_RESET  = 14'd58;
   localparam logic [13:0] PERIOD_FOURTH_RESET = 14'd157;

   // Even-parity code of the two flags, indexed by {mail, 0, low_battery}: the index bits followed by their parity
   function automatic logic [3:0] flag_code(input logic [2:0] sel);
      logic [3:0] code;
      case (sel)
         3'd0:    code = 4'd0;
         3'd1:    code = 4'd3;
         3'd2:    code = 4'd5;
         3'd3:    code = 4'd6;
         3'd4:    code = 4'd9;
         3'd5:    code = 4'd10;
         3'd6:    code = 4'd12;
         default: code = 4'd15;
      endcase
      return code;
   endfunction

endpackage

// ===== src/alert_repeat_scheduler.sv =====
// Alert repeat scheduler.
// req_ channel: one transfer per wake tick, carrying the contact sensor state and a
// battery ADC sample. rsp_ channel: exactly one result per tick, in order, with the
// send strobe, the 12-bit alert message (zero when nothing is sent), whether the
// battery sample was evaluated, and both flags after the tick.
// csr_ channel: register writes, always ready; indexes beyond the list are ignored.
// Write registers only while no tick is in flight.
// A tick is registered at the input register, evaluated by the single evaluation stage and
// lands in the result register, from which its result is offered. Throughput: one tick
// per cycle while rsp_ready is high; the single evaluation stage between the input and
// result registers sets that figure.
// When rsp_ready is low the result register holds, the input register fills behind
// it and req_ready drops; no item is lost or repeated.
// Reset (synchronous, active high) loads the register defaults, clears both flags,
// the repeat index and both countdowns, and empties the pipeline; the first tick
// after reset therefore performs a battery check.
module alert_repeat_scheduler (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ars_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ars_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [15:0]      csr_data
);
   import ars_pkg::*;

   // configuration
   logic [9:0]  threshold_ff;
   logic [15:0] interval_ff;
   logic [13:0] period_ff [4];

   // scheduler state
   logic        mail_ff, mail_in;
   logic        low_ff, low_in;
   logic [2:0]  idx_ff, idx_in;
   logic [15:0] tx_cnt_ff, tx_cnt_in;
   logic [15:0] bat_cnt_ff, bat_cnt_in;

   // pipeline
   logic    req_valid_ff;
   req_type req_data_ff;
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff, rsp_data_in;
   logic    advance;

   // evaluation intermediates
   logic        mail_set, check, low_sample, restart_bat;
   logic        mail1, low1;
   logic [2:0]  idx1;
   logic [15:0] tx1;

   assign csr_ready = 1'b1;
   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         interval_ff  <= INTERVAL_RESET;
         period_ff[0] <= PERIOD_FIRST_RESET;
         period_ff[1] <= PERIOD_SECOND_RESET;
         period_ff[2] <= PERIOD_THIRD_RESET;
         period_ff[3] <= PERIOD_FOURTH_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_LOW_BATTERY_THRESHOLD:  threshold_ff <= csr_data[9:0];
            REG_BATTERY_CHECK_INTERVAL: interval_ff  <= csr_data;
            REG_REPEAT_PERIOD_FIRST:    period_ff[0] <= csr_data[13:0];
            REG_REPEAT_PERIOD_SECOND:   period_ff[1] <= csr_data[13:0];
            REG_REPEAT_PERIOD_THIRD:    period_ff[2] <= csr_data[13:0];
            REG_REPEAT_PERIOD_FOURTH:   period_ff[3] <= csr_data[13:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      mail_set    = req_data_ff.sense_active && !mail_ff;
      mail1       = mail_ff || req_data_ff.sense_active;
      check       = (bat_cnt_ff == 16'd0);
      low_sample  = (req_data_ff.battery_sample < threshold_ff);
      restart_bat = check && low_sample;
      low1        = check ? low_sample : low_ff;
      tx1         = (mail_set || restart_bat) ? 16'd0 : tx_cnt_ff;
      idx1        = (mail_set || restart_bat) ? 3'd0 : idx_ff;
      bat_cnt_in  = check ? interval_ff : bat_cnt_ff - 16'd1;

      mail_in     = mail1;
      low_in      = low1;
      idx_in      = idx1;
      tx_cnt_in   = tx1 - 16'd1;
      rsp_data_in = '0;
      if (tx1 == 16'd0) begin
         if (idx1 < REPEAT_COUNT) begin
            rsp_data_in.send_now      = 1'b1;
            rsp_data_in.alert_message = MSG_BASE | {8'd0, flag_code({mail1, 1'b0, low1})};
            // 4 ticks per second
            tx_cnt_in = {period_ff[idx1[1:0]], 2'b00};
            idx_in    = idx1 + 3'd1;
         end else begin
            mail_in   = 1'b0;
            tx_cnt_in = tx1;
         end
      end
      rsp_data_in.battery_used    = check;
      rsp_data_in.mail_flag_out   = mail_in;
      rsp_data_in.low_battery_out = low_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mail_ff      <= 1'b0;
         low_ff       <= 1'b0;
         idx_ff       <= 3'd0;
         tx_cnt_ff    <= 16'd0;
         bat_cnt_ff   <= 16'd0;
      end else begin
         if (req_ready) begin
            req_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            mail_ff      <= mail_in;
            low_ff       <= low_in;
            idx_ff       <= idx_in;
            tx_cnt_ff    <= tx_cnt_in;
            bat_cnt_ff   <= bat_cnt_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= REPEAT_COUNT)
      else $error("repeat index beyond repeat count");

   a_msg_send: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.send_now == (rsp_data_ff.alert_message != 12'd0)))
      else $error("alert message does not match send strobe");

   a_advance_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("evaluated tick produced no result");

   a_bat_reload: assert property (@(posedge clock) disable iff (reset)
      (advance && check) |=> (bat_cnt_ff == $past(interval_ff)))
      else $error("battery countdown not reloaded after check");

   a_mail_follows: assert property (@(posedge clock) disable iff (reset)
      advance |=> (rsp_data_ff.mail_flag_out == mail_ff && rsp_data_ff.low_battery_out == low_ff))
      else $error("reported flags differ from state");

endmodule

// ===== bench/alert_repeat_scheduler_checker.sv =====
`timescale 1ns / 1ps

module alert_repeat_scheduler_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  ars_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  ars_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   input  logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [15:0]      csr_data,
   output int               mismatch_count,
   output int               pending_count,
   output int               send_count,
   output int               check_count
);

   // register copies
   logic [9:0]  threshold;
   logic [15:0] check_interval;
   logic [13:0] period [0:3];

   // scheduler state
   logic        mail_latched;
   logic        battery_low;
   logic [2:0]  repeat_step;
   logic [15:0] send_countdown;
   logic [15:0] battery_countdown;

   ars_pkg::rsp_type pending_alerts [$];
   ars_pkg::rsp_type want;

   function automatic ars_pkg::rsp_type run_wake_tick(input ars_pkg::req_type tick);
      ars_pkg::rsp_type res;
      res = '0;
      if (tick.sense_active && !mail_latched) begin
         mail_latched = 1'b1;
         send_countdown = '0;
         repeat_step = '0;
      end
      if (battery_countdown == 16'd0) begin
         res.battery_used = 1'b1;
         if (tick.battery_sample < threshold) begin
            battery_low = 1'b1;
            send_countdown = '0;
            repeat_step = '0;
         end else begin
            battery_low = 1'b0;
         end
         battery_countdown = check_interval;
      end else begin
         battery_countdown = battery_countdown - 16'd1;
      end
      if (send_countdown == 16'd0) begin
         if (repeat_step < ars_pkg::REPEAT_COUNT) begin
            res.send_now = 1'b1;
            // code of {mail, 0, low} is the index bits followed by their parity
            res.alert_message = ars_pkg::MSG_BASE |
               {8'd0, mail_latched, 1'b0, battery_low, mail_latched ^ battery_low};
            send_countdown = {period[repeat_step[1:0]], 2'b00};
            repeat_step = repeat_step + 3'd1;
         end else begin
            mail_latched = 1'b0;
         end
      end else begin
         send_countdown = send_countdown - 16'd1;
      end
      res.mail_flag_out = mail_latched;
      res.low_battery_out = battery_low;
      return res;
   endfunction

   task automatic compare_field(input string field, input logic [11:0] want_v,
                                input logic [11:0] got_v);
      if (got_v !== want_v) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want_v, got_v);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         threshold = ars_pkg::THRESHOLD_RESET;
         check_interval = ars_pkg::INTERVAL_RESET;
         period[0] = ars_pkg::PERIOD_FIRST_RESET;
         period[1] = ars_pkg::PERIOD_SECOND_RESET;
         period[2] = ars_pkg::PERIOD_THIRD_RESET;
         period[3] = ars_pkg::PERIOD_FOURTH_RESET;
         mail_latched = 1'b0;
         battery_low = 1'b0;
         repeat_step = '0;
         send_countdown = '0;
         battery_countdown = '0;
         pending_alerts.delete();
         mismatch_count = 0;
         send_count = 0;
         check_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_alerts.size() == 0) begin
               $display("%0t: result transfer with nothing expected, actual %0h",
                        $time, rsp_data);
               mismatch_count++;
            end else begin
               want = pending_alerts.pop_front();
               compare_field("send_now", 12'(want.send_now), 12'(rsp_data.send_now));
               compare_field("alert_message", want.alert_message, rsp_data.alert_message);
               compare_field("battery_used", 12'(want.battery_used),
                             12'(rsp_data.battery_used));
               compare_field("mail_flag_out", 12'(want.mail_flag_out),
                             12'(rsp_data.mail_flag_out));
               compare_field("low_battery_out", 12'(want.low_battery_out),
                             12'(rsp_data.low_battery_out));
            end
            if (rsp_data.send_now) send_count++;
            if (rsp_data.battery_used) check_count++;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               ars_pkg::REG_LOW_BATTERY_THRESHOLD:  threshold = csr_data[9:0];
               ars_pkg::REG_BATTERY_CHECK_INTERVAL: check_interval = csr_data;
               ars_pkg::REG_REPEAT_PERIOD_FIRST:    period[0] = csr_data[13:0];
               ars_pkg::REG_REPEAT_PERIOD_SECOND:   period[1] = csr_data[13:0];
               ars_pkg::REG_REPEAT_PERIOD_THIRD:    period[2] = csr_data[13:0];
               ars_pkg::REG_REPEAT_PERIOD_FOURTH:   period[3] = csr_data[13:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) pending_alerts.push_back(run_wake_tick(req_data));
      end
      pending_count = pending_alerts.size();
   end

endmodule

// ===== bench/alert_repeat_scheduler_test.sv =====
`timescale 1ns / 1ps

module alert_repeat_scheduler_test;

   localparam logic [2:0] REG_SPARE_SIX   = 3'd6;
   localparam logic [2:0] REG_SPARE_SEVEN = 3'd7;
   localparam int RANDOM_PHASES = 8;
   localparam int TICKS_PER_PHASE = 148;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   ars_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   ars_pkg::rsp_type rsp_data;
   logic             csr_valid;
   logic             csr_ready;
   logic [2:0]       csr_index;
   logic [15:0]      csr_data;

   int mismatch_count;
   int pending_count;
   int send_count;
   int check_count;
   int ticks_sent;
   int settings_used;
   int hold_requests;
   bit jitter_on;

   alert_repeat_scheduler dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   alert_repeat_scheduler_checker tick_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .mismatch_count(mismatch_count),
      .pending_count(pending_count),
      .send_count(send_count),
      .check_count(check_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("alert_repeat_scheduler_test failed");
      $finish;
   end

   // result side: random back-pressure, plus long holds on request
   initial begin
      int holds_served;
      holds_served = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (holds_served != hold_requests) begin
            holds_served++;
            rsp_ready <= 1'b0;
            repeat (60) @(negedge clock);
         end else begin
            rsp_ready <= !(jitter_on && $urandom_range(99) < 14);
         end
      end
   end

   task automatic write_reg(input logic [2:0] index, input logic [15:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_tick(input logic sense, input logic [9:0] sample);
      ars_pkg::req_type tick;
      tick.sense_active = sense;
      tick.battery_sample = sample;
      while (jitter_on && $urandom_range(99) < 14) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= tick;
      do @(posedge clock); while (!req_ready);
      ticks_sent++;
   endtask

   // stop offering and let every in-flight tick drain
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending_count == 0);
      repeat (4) @(posedge clock);
   endtask

   // mostly short periods so sequences finish; top bits exercise the masking
   function automatic logic [15:0] pick_period(input int phase, input int slot);
      if (phase == 5 && slot == 3) return 16'hFFFF;
      return {2'($urandom), 14'($urandom_range(5))};
   endfunction

   task automatic load_config(input int phase);
      write_reg(ars_pkg::REG_LOW_BATTERY_THRESHOLD,
                phase == 1 ? 16'h0000 : phase == 2 ? 16'hFFFF : 16'($urandom));
      write_reg(ars_pkg::REG_BATTERY_CHECK_INTERVAL,
                phase == 3 ? 16'hFFFF : phase == 4 ? 16'h0000 : 16'($urandom_range(40)));
      write_reg(ars_pkg::REG_REPEAT_PERIOD_FIRST, pick_period(phase, 0));
      write_reg(ars_pkg::REG_REPEAT_PERIOD_SECOND, pick_period(phase, 1));
      write_reg(ars_pkg::REG_REPEAT_PERIOD_THIRD, pick_period(phase, 2));
      write_reg(ars_pkg::REG_REPEAT_PERIOD_FOURTH, pick_period(phase, 3));
      settings_used++;
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      ticks_sent = 0;
      settings_used = 1;
      hold_requests = 0;
      jitter_on = 1'b1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // power-up defaults: first tick checks the battery, just under threshold
      send_tick(1'b0, 10'd634);
      send_tick(1'b1, 10'd1023);
      send_tick(1'b1, 10'd0);      // sensor while latched
      send_tick(1'b0, 10'd512);
      send_tick(1'b0, 10'd1023);
      send_tick(1'b1, 10'd0);
      drain();

      // check every tick, zero periods, full-scale threshold; spare indexes ignored
      write_reg(ars_pkg::REG_LOW_BATTERY_THRESHOLD, 16'hFFFF);
      write_reg(ars_pkg::REG_BATTERY_CHECK_INTERVAL, 16'h0000);
      write_reg(ars_pkg::REG_REPEAT_PERIOD_FIRST, 16'h0000);
      write_reg(ars_pkg::REG_REPEAT_PERIOD_SECOND, 16'hC000);
      write_reg(ars_pkg::REG_REPEAT_PERIOD_THIRD, 16'h0000);
      write_reg(ars_pkg::REG_REPEAT_PERIOD_FOURTH, 16'h4000);
      write_reg(REG_SPARE_SIX, 16'hFFFF);
      write_reg(REG_SPARE_SEVEN, 16'h0001);
      settings_used++;
      send_tick(1'b0, 10'd1022);   // low battery restarts
      send_tick(1'b0, 10'd1023);
      send_tick(1'b1, 10'd1023);   // mail restarts
      for (int i = 0; i < 6; i++) send_tick(1'b0, 10'd1023);  // run out the repeats
      send_tick(1'b1, 10'd1023);
      send_tick(1'b0, 10'd0);
      send_tick(1'b1, 10'd1023);
      drain();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         load_config(phase);
         jitter_on = (phase != 6);
         if (phase == 2) hold_requests++;
         for (int i = 0; i < TICKS_PER_PHASE; i++)
            send_tick(1'($urandom_range(99) < 8), 10'($urandom_range(1023)));
         drain();
      end

      repeat (10) @(posedge clock);
      $display("covered %0d ticks under %0d register settings", ticks_sent, settings_used);
      $display("saw %0d sends and %0d battery checks", send_count, check_count);
      if (mismatch_count == 0) begin
         $display("alert_repeat_scheduler_test passed");
      end else begin
         $display("alert_repeat_scheduler_test failed");
      end
      $finish;
   end

endmodule

// ===== alert_repeat_scheduler.f =====
src/ars_pkg.sv
src/alert_repeat_scheduler.sv
bench/alert_repeat_scheduler_checker.sv
bench/alert_repeat_scheduler_test.sv
